// ===== rtl/rfr_pkg.sv =====
`default_nettype none
package rfr_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned POS_W     = 9;
    localparam int unsigned BUDGET_W  = 24;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 24;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT_POLLS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_EXPECTED_DIR  = 2'd1;

    // Reset values of the configuration registers
    localparam logic [BUDGET_W-1:0] TIMEOUT_POLLS_RST = 24'd50000;
    localparam logic [BYTE_W-1:0]   EXPECTED_DIR_RST  = 8'hD5;

    // Start code and trailer size
    localparam logic [BYTE_W-1:0] PREAMBLE_BYTE = 8'h00;
    localparam logic [BYTE_W-1:0] START_BYTE    = 8'hFF;
    localparam logic [POS_W:0]    TRAILER_BYTES = 10'd4;

    // Result status codes
    typedef logic [1:0] status_t;
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_FRAME   = 2'd1;
    localparam status_t ST_TIMEOUT = 2'd2;

    // Receiver phase
    typedef enum logic [1:0] {
        PH_HUNT_ZERO = 2'd0,
        PH_HUNT_FF   = 2'd1,
        PH_CAPTURE   = 2'd2
    } phase_t;

    // One poll request
    typedef struct packed {
        logic              cmd;
        logic [BYTE_W-1:0] rx_byte;
    } item_t;

    // One result
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [POS_W-1:0]  position;
        logic              byte_valid;
        logic              last;
        status_t           status;
        logic [BYTE_W-1:0] payload_length;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/response_frame_receiver_core.sv =====
`default_nettype none
// Frame receiver: each request is one UART poll (idle, or carrying a received
// byte). The core hunts for the 00 FF start code, then streams out LEN and the
// LEN+3 bytes after it with their positions, closing the frame on the last
// byte with ok or frame-error status. Every poll spends one unit of the
// timeout budget; an empty budget gives a timeout result and re-arms. One
// request is taken every cycle while the output register can take a result:
// it waits in the input register, then its state update and result are formed
// in a single pass into the output register.
// s_tready follows m_tready combinationally through the output register when
// both stages are full. Writing timeout_polls reloads the budget at once.
module response_frame_receiver_core
    import rfr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] rx_byte
    input  wire logic                  s_tuser,   // [0] cmd
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [31:0]                m_tdata,   // [7:0] data_byte, [16:8] position,
                                                  // [24:17] payload_length, [31:25] zero
    output logic [2:0]                 m_tuser,   // [0] byte_valid, [2:1] status
    output logic                       m_tlast    // frame end or timeout
);

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    logic    can_load;
    logic    emit;
    result_t result;
    result_t result_out;

    assign s_item.cmd     = s_tuser;
    assign s_item.rx_byte = s_tdata;

    // Move a request on only when its result has somewhere to go
    assign advance = item_valid && can_load;

    rfr_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    rfr_frame_ctrl u_frame_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .step      (advance),
        .item      (item),
        .emit      (emit),
        .result    (result)
    );

    rfr_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance && emit),
        .result_in  (result),
        .can_load   (can_load),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .result_out (result_out)
    );

    // Pack the result
    assign m_tdata = {7'd0, result_out.payload_length, result_out.position,
                      result_out.data_byte};
    assign m_tuser = {result_out.status, result_out.byte_valid};
    assign m_tlast = result_out.last;

    // A result without a byte is always a timeout closing the reception
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tlast && (m_tuser[2:1] == ST_TIMEOUT)))
        else $error("byte-less result is not a timeout");

    // Status is only reported on the closing result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tuser[2:1] == ST_OK && m_tdata[24:17] == 8'd0))
        else $error("status or length on a mid-frame byte");

    // An ok frame closes at position LEN+3, i.e. payload length plus four
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast && m_tuser[2:1] == ST_OK)
            |-> (m_tdata[16:8] == ({1'b0, m_tdata[24:17]} + 9'd4)))
        else $error("ok frame closed at wrong position");

    // Nothing leaves the input register while the output register is blocked
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready && item_valid) |=> item_valid)
        else $error("request dropped while output stalled");

endmodule
`default_nettype wire

// ===== rtl/rfr_in_stage.sv =====
`default_nettype none
module rfr_in_stage
    import rfr_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_tvalid,
    output logic       s_tready,
    input  wire item_t s_item,
    input  wire logic  advance,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg, valid_next;
    item_t item_reg;
    logic  take;

    // Accept a new request when empty or when the held one moves on
    assign s_tready = !valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload
    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

// ===== rtl/rfr_frame_ctrl.sv =====
`default_nettype none
module rfr_frame_ctrl
    import rfr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  step,
    input  wire item_t                 item,
    output logic                       emit,
    output result_t                    result
);

    logic [BUDGET_W-1:0] timeout_polls_reg;
    logic [BYTE_W-1:0]   expected_dir_reg;
    phase_t              phase_reg, phase_next;
    logic [POS_W-1:0]    byte_index_reg, byte_index_next;
    logic [BYTE_W-1:0]   frame_length_reg, frame_length_next;
    logic                dir_ok_reg, dir_ok_next;
    logic [BUDGET_W-1:0] polls_left_reg, polls_left_next;

    logic                byte_ev;
    logic                captured;
    logic                done;
    logic                timeout;
    logic                frame_ok;
    logic [BYTE_W-1:0]   len_now;
    logic [POS_W:0]      pos_plus_one;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_polls_reg <= TIMEOUT_POLLS_RST;
            expected_dir_reg  <= EXPECTED_DIR_RST;
        end else if (cfg_wr_en) begin
            if (cfg_addr == REG_TIMEOUT_POLLS) begin
                timeout_polls_reg <= cfg_wdata;
            end
            if (cfg_addr == REG_EXPECTED_DIR) begin
                expected_dir_reg <= cfg_wdata[BYTE_W-1:0];
            end
        end
    end

    // Decode the poll against the current phase
    assign byte_ev      = step && item.cmd;
    assign captured     = byte_ev && (phase_reg == PH_CAPTURE);
    assign len_now      = (byte_index_reg == '0) ? item.rx_byte : frame_length_reg;
    assign pos_plus_one = {1'b0, byte_index_reg} + 10'd1;
    assign done         = captured && (pos_plus_one >= ({2'b00, len_now} + TRAILER_BYTES));
    assign timeout      = step && !done && (polls_left_reg <= 24'd1);
    assign frame_ok     = dir_ok_reg && (frame_length_reg != '0);

    // Next state
    always_comb begin
        phase_next        = phase_reg;
        byte_index_next   = byte_index_reg;
        frame_length_next = frame_length_reg;
        dir_ok_next       = dir_ok_reg;
        polls_left_next   = polls_left_reg;
        if (step) begin
            if (done || timeout) begin
                // Re-arm with a full budget
                phase_next        = PH_HUNT_ZERO;
                byte_index_next   = '0;
                frame_length_next = '0;
                dir_ok_next       = 1'b0;
                polls_left_next   = timeout_polls_reg;
            end else begin
                polls_left_next = polls_left_reg - 24'd1;
                if (item.cmd) begin
                    unique case (phase_reg)
                        PH_HUNT_ZERO: begin
                            if (item.rx_byte == PREAMBLE_BYTE) begin
                                phase_next = PH_HUNT_FF;
                            end
                        end
                        PH_HUNT_FF: begin
                            if (item.rx_byte == START_BYTE) begin
                                phase_next      = PH_CAPTURE;
                                byte_index_next = '0;
                                dir_ok_next     = 1'b0;
                            end else if (item.rx_byte != PREAMBLE_BYTE) begin
                                phase_next = PH_HUNT_ZERO;
                            end
                        end
                        PH_CAPTURE: begin
                            if (byte_index_reg == 9'd0) begin
                                frame_length_next = item.rx_byte;
                            end
                            if (byte_index_reg == 9'd2) begin
                                dir_ok_next = (item.rx_byte == expected_dir_reg);
                            end
                            byte_index_next = pos_plus_one[POS_W-1:0];
                        end
                        default: begin
                            phase_next = PH_HUNT_ZERO;
                        end
                    endcase
                end
            end
        end
        // Budget write reloads the counter
        if (cfg_wr_en && (cfg_addr == REG_TIMEOUT_POLLS)) begin
            polls_left_next = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HUNT_ZERO;
            byte_index_reg   <= '0;
            frame_length_reg <= '0;
            dir_ok_reg       <= 1'b0;
            polls_left_reg   <= TIMEOUT_POLLS_RST;
        end else begin
            phase_reg        <= phase_next;
            byte_index_reg   <= byte_index_next;
            frame_length_reg <= frame_length_next;
            dir_ok_reg       <= dir_ok_next;
            polls_left_reg   <= polls_left_next;
        end
    end

    // Result fields
    always_comb begin
        emit   = done || timeout || captured;
        result = '0;
        if (done) begin
            result.data_byte  = item.rx_byte;
            result.position   = byte_index_reg;
            result.byte_valid = 1'b1;
            result.last       = 1'b1;
            result.status     = frame_ok ? ST_OK : ST_FRAME;
            result.payload_length = frame_ok ? (frame_length_reg - 8'd1) : '0;
        end else if (timeout) begin
            result.last   = 1'b1;
            result.status = ST_TIMEOUT;
        end else if (captured) begin
            result.data_byte  = item.rx_byte;
            result.position   = byte_index_reg;
            result.byte_valid = 1'b1;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/rfr_out_stage.sv =====
`default_nettype none
module rfr_out_stage
    import rfr_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    load,
    input  wire result_t result_in,
    output logic         can_load,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    output result_t      result_out
);

    logic    valid_reg, valid_next;
    result_t result_reg;

    // Free when empty or when the held result leaves this cycle
    assign can_load = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_in;
        end
    end

    assign m_tvalid   = valid_reg;
    assign result_out = result_reg;

endmodule
`default_nettype wire

// ===== verif/frame_result_checker.sv =====
`timescale 1ns / 100ps
// Watches both streams and the register port, keeps its own copy of the
// receiver state and compares every accepted result with the oldest one owed.
module frame_result_checker
    import rfr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] rx_byte
    input  wire logic                  s_tuser,   // [0] cmd
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [31:0]           m_tdata,   // [7:0] data_byte, [16:8] position,
                                                  // [24:17] payload_length, [31:25] zero
    input  wire logic [2:0]            m_tuser,   // [0] byte_valid, [2:1] status
    input  wire logic                  m_tlast,
    output int unsigned                mismatch_count,
    output int unsigned                results_owed
);

    // Register copies
    logic [BUDGET_W-1:0] budget_cfg;
    logic [BYTE_W-1:0]   dir_cfg;

    // Receiver state copy
    phase_t              phase;
    logic [POS_W-1:0]    byte_idx;
    logic [BYTE_W-1:0]   frame_len;
    logic                dir_match;
    logic [BUDGET_W-1:0] polls_left;

    result_t owed_results[$];

    initial begin
        mismatch_count = 0;
        results_owed   = 0;
    end

    // Return to the hunt with a full budget
    task rearm_receiver();
        phase      = PH_HUNT_ZERO;
        byte_idx   = '0;
        frame_len  = '0;
        dir_match  = 1'b0;
        polls_left = budget_cfg;
    endtask

    // Advance the receiver by one poll and queue the result it owes, if any
    task predict_poll(input logic cmd, input logic [BYTE_W-1:0] rx);
        result_t r;
        logic    captured;
        logic    done;
        int      pos;
        r        = '0;
        captured = 1'b0;
        done     = 1'b0;
        pos      = 0;
        if (cmd) begin
            case (phase)
                PH_HUNT_ZERO: begin
                    if (rx == PREAMBLE_BYTE) phase = PH_HUNT_FF;
                end
                PH_HUNT_FF: begin
                    if (rx == START_BYTE) begin
                        phase     = PH_CAPTURE;
                        byte_idx  = '0;
                        dir_match = 1'b0;
                    end else if (rx != PREAMBLE_BYTE) begin
                        phase = PH_HUNT_ZERO;
                    end
                end
                default: begin
                    pos = byte_idx;
                    if (pos == 0) frame_len = rx;
                    if (pos == 2) dir_match = (rx == dir_cfg);
                    captured = 1'b1;
                    if (pos + 1 >= int'(frame_len) + int'(TRAILER_BYTES)) done = 1'b1;
                    else byte_idx = byte_idx + 1'b1;
                end
            endcase
        end

        if (done) begin
            // Close the frame; status depends on direction byte and LEN
            r.data_byte  = rx;
            r.position   = pos[POS_W-1:0];
            r.byte_valid = 1'b1;
            r.last       = 1'b1;
            if (dir_match && frame_len != 0) begin
                r.status         = ST_OK;
                r.payload_length = frame_len - 1'b1;
            end else begin
                r.status = ST_FRAME;
            end
            owed_results.push_back(r);
            rearm_receiver();
        end else if (polls_left <= 1) begin
            // Budget spent: drop any byte and report a timeout
            r.last   = 1'b1;
            r.status = ST_TIMEOUT;
            owed_results.push_back(r);
            rearm_receiver();
        end else begin
            polls_left = polls_left - 1'b1;
            if (captured) begin
                r.data_byte  = rx;
                r.position   = pos[POS_W-1:0];
                r.byte_valid = 1'b1;
                owed_results.push_back(r);
            end
        end
    endtask

    task compare_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    // Match one accepted result against the oldest one owed
    task check_result();
        result_t want;
        if (owed_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: result expected none got tdata %h tuser %h tlast %b",
                     $time, m_tdata, m_tuser, m_tlast);
        end else begin
            want = owed_results.pop_front();
            compare_field("data_byte", want.data_byte, m_tdata[7:0]);
            compare_field("position", want.position, m_tdata[16:8]);
            compare_field("payload_length", want.payload_length, m_tdata[24:17]);
            compare_field("tdata pad", 0, m_tdata[31:25]);
            compare_field("byte_valid", want.byte_valid, m_tuser[0]);
            compare_field("status", want.status, m_tuser[2:1]);
            compare_field("last", want.last, m_tlast);
        end
    endtask

    // Sample all channels at the clock edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            budget_cfg = TIMEOUT_POLLS_RST;
            dir_cfg    = EXPECTED_DIR_RST;
            rearm_receiver();
            owed_results.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == REG_TIMEOUT_POLLS) begin
                    budget_cfg = cfg_wdata[BUDGET_W-1:0];
                    polls_left = budget_cfg;
                end else if (cfg_addr == REG_EXPECTED_DIR) begin
                    dir_cfg = cfg_wdata[BYTE_W-1:0];
                end
            end
            if (m_tvalid && m_tready) check_result();
            if (s_tvalid && s_tready) predict_poll(s_tuser, s_tdata);
        end
        results_owed <= owed_results.size();
    end

endmodule

// ===== verif/response_frame_receiver_core_tb.sv =====
`timescale 1ns / 100ps
module response_frame_receiver_core_tb;
    import rfr_pkg::*;

    // Register indexes past the defined pair
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 2'd3;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;   // [7:0] rx_byte
    logic                  s_tuser   = 1'b0; // [0] cmd
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [31:0]           m_tdata;          // [7:0] data_byte, [16:8] position,
                                             // [24:17] payload_length, [31:25] zero
    logic [2:0]            m_tuser;          // [0] byte_valid, [2:1] status
    logic                  m_tlast;

    int unsigned       mismatch_count;
    int unsigned       results_owed;
    int unsigned       polls_sent = 0;
    int unsigned       ready_hold = 0;
    bit                no_idle    = 1'b0;
    logic [BYTE_W-1:0] dir_now    = EXPECTED_DIR_RST;

    response_frame_receiver_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    frame_result_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .mismatch_count(mismatch_count), .results_owed(results_owed)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #3000000;
        $display("response_frame_receiver_core regression: fail");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    // Mostly short frames, a few long ones
    function automatic int unsigned pick_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return $urandom_range(0, 8);
        if (roll < 95) return $urandom_range(9, 40);
        if (roll < 99) return $urandom_range(41, 254);
        return 255;
    endfunction

    // Toggle result backpressure between ready runs and stalls
    always @(posedge aclk) begin
        if (no_idle) begin
            m_tready <= 1'b1;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            m_tready   <= !m_tready;
            ready_hold <= m_tready ? pick_gap() : $urandom_range(0, 24);
        end
    end

    // Offer one poll request and hold it until accepted
    task automatic send_poll(input logic cmd, input logic [7:0] rx);
        int unsigned gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= rx;
        do @(posedge aclk); while (!s_tready);
        polls_sent++;
    endtask

    // Send the start code and the first count frame bytes, with stray idle polls
    task automatic send_frame(input int unsigned len, input logic [7:0] dir,
                              input int unsigned count);
        int unsigned p;
        send_poll(1'b1, PREAMBLE_BYTE);
        send_poll(1'b1, START_BYTE);
        for (p = 0; p < count; p++) begin
            if ($urandom_range(0, 9) == 0) send_poll(1'b0, 8'($urandom));
            if (p == 0) send_poll(1'b1, len[7:0]);
            else if (p == 2) send_poll(1'b1, dir);
            else send_poll(1'b1, 8'($urandom));
        end
    endtask

    // Drain the block, then write one register
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (addr == REG_EXPECTED_DIR) dir_now = value[BYTE_W-1:0];
    endtask

    initial begin
        int unsigned         target;
        int unsigned         chunk_end;
        int unsigned         roll;
        int unsigned         len;
        int unsigned         p;
        logic [BUDGET_W-1:0] budget;
        logic [7:0]          dir;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Hunt: idle poll, restarts, repeated zeros, FF without a zero
        send_poll(1'b0, PREAMBLE_BYTE);
        send_poll(1'b0, START_BYTE);
        send_poll(1'b1, 8'h55);
        send_poll(1'b1, PREAMBLE_BYTE);
        send_poll(1'b1, PREAMBLE_BYTE);
        send_poll(1'b1, 8'h12);
        send_poll(1'b1, START_BYTE);
        // LEN zero, wrong direction, then a good one-byte payload
        send_frame(0, dir_now, 4);
        send_frame(1, ~dir_now, 5);
        send_frame(2, dir_now, 6);

        // Budget of one and of zero: every poll times out, bytes dropped
        write_reg(REG_TIMEOUT_POLLS, 24'd1);
        send_poll(1'b1, PREAMBLE_BYTE);
        send_poll(1'b1, START_BYTE);
        send_poll(1'b0, 8'hFF);
        write_reg(REG_TIMEOUT_POLLS, '0);
        send_poll(1'b1, PREAMBLE_BYTE);
        send_poll(1'b0, 8'h00);

        // Timeout in the middle of a capture
        write_reg(REG_TIMEOUT_POLLS, 24'd5);
        send_frame(6, dir_now, 10);

        // Budget reload mid-capture keeps the frame going
        write_reg(REG_TIMEOUT_POLLS, 24'd300);
        send_frame(4, dir_now, 3);
        write_reg(REG_TIMEOUT_POLLS, 24'd200);
        for (p = 3; p < 8; p++) send_poll(1'b1, 8'($urandom));

        // Direction extremes and writes to unused indexes
        write_reg(REG_EXPECTED_DIR, 24'h00);
        send_frame(3, 8'h00, 7);
        write_reg(REG_EXPECTED_DIR, 24'hFF);
        write_reg(REG_SPARE_LO, 24'($urandom));
        write_reg(REG_SPARE_HI, '1);
        send_frame(2, 8'hFF, 6);

        // Longest frame under the widest budget
        write_reg(REG_TIMEOUT_POLLS, '1);
        send_frame(255, dir_now, 259);

        // Random phases: new settings, then frames, broken frames and noise
        target = 1300;
        while (polls_sent < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) budget = 24'($urandom_range(1, 4));
            else if (roll < 30) budget = 24'($urandom_range(5, 40));
            else if (roll < 85) budget = 24'($urandom_range(41, 2000));
            else if (roll < 95) budget = '1;
            else budget = '0;
            write_reg(REG_TIMEOUT_POLLS, budget);
            if ($urandom_range(0, 2) == 0) begin
                roll = $urandom_range(0, 3);
                if (roll == 0) write_reg(REG_EXPECTED_DIR, 24'h00);
                else if (roll == 1) write_reg(REG_EXPECTED_DIR, 24'hFF);
                else if (roll == 2) write_reg(REG_EXPECTED_DIR, 24'(EXPECTED_DIR_RST));
                else write_reg(REG_EXPECTED_DIR, 24'($urandom_range(0, 255)));
            end
            no_idle   = ($urandom_range(0, 5) == 0);
            chunk_end = polls_sent + $urandom_range(40, 160);
            while (polls_sent < chunk_end) begin
                roll = $urandom_range(0, 99);
                len  = pick_len();
                if (roll < 65) begin
                    dir = ($urandom_range(0, 6) == 0) ? 8'($urandom) : dir_now;
                    send_frame(len, dir, len + 4);
                end else if (roll < 75) begin
                    send_frame(len, dir_now, $urandom_range(0, len + 3));
                end else begin
                    repeat ($urandom_range(1, 6)) begin
                        roll = $urandom_range(0, 9);
                        if (roll < 3) send_poll(1'($urandom_range(0, 1)), PREAMBLE_BYTE);
                        else if (roll < 5) send_poll(1'($urandom_range(0, 1)), START_BYTE);
                        else send_poll(1'($urandom_range(0, 1)), 8'($urandom));
                    end
                end
            end
        end

        // Drain and give the verdict
        s_tvalid <= 1'b0;
        no_idle = 1'b0;
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && results_owed == 0) begin
            $display("response_frame_receiver_core regression: pass");
        end else begin
            $display("response_frame_receiver_core regression: fail");
        end
        $finish;
    end

endmodule
